@@ rtl/core/urf_pkg.sv @@
// shared constants and types for the uart 8n1 receiver with fifo
package urf_pkg;

    localparam int FIFO_DEPTH    = 256;
    localparam int ADDR_W        = $clog2(FIFO_DEPTH);
    localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);
    localparam int OUT_COUNT_W   = 9;
    localparam int DATA_W        = 8;
    localparam int PERIOD_W      = 16;
    localparam int TICK_W        = PERIOD_W + 1;
    localparam int BITS_W        = 4;
    localparam int BITS_PER_WORD = 8;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd104;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    typedef enum logic {
        RX_IDLE = 1'b0,
        RX_DATA = 1'b1
    } t_rx_state;

    // finished word from the receiver
    typedef struct packed {
        logic              push;
        logic [DATA_W-1:0] data;
    } t_rx_word;

    // fifo status after the current item
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             overflow;
        logic             pop_ok;
    } t_fifo_status;

endpackage

@@ rtl/core/uart_8n1_receiver_fifo.sv @@
// top level of the tick-driven 8n1 uart receiver with receive fifo
// Each input word is either a tick carrying one sample of the receive line
// (action 0) or a read that pops one byte from the 256-entry receive fifo
// (action 1); every word gives exactly one result word. A falling line
// while idle starts a frame: the first data bit is taken one and a half bit
// periods later, then one bit each bit_period ticks, lsb first, eight bits;
// the stop bit is not checked. Throughput is one word per clock while the
// output side keeps up. An accepted word passes through a stage for the
// synchronous read of the fifo memory and then through the output
// register, which drives o_out_valid. A full fifo drops the new byte
// and sets the sticky overflow flag. No clearing pass is needed after
// reset, since a fifo entry is only read after it was written. Write
// bit_period only while idle.
module uart_8n1_receiver_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [urf_pkg::PERIOD_W-1:0]    i_cfg_wr_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_action,
    input  logic                            i_rx_line,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_read_valid,
    output logic [urf_pkg::DATA_W-1:0]      o_read_data,
    output logic                            o_byte_done,
    output logic [urf_pkg::OUT_COUNT_W-1:0] o_fifo_count,
    output logic                            o_overflow
);

    logic [urf_pkg::PERIOD_W-1:0] r_bit_period;

    // stage one: state already updated, waiting on the fifo read data
    logic                            r_s1_valid;
    logic                            r_s1_read_valid;
    logic                            r_s1_byte_done;
    logic [urf_pkg::OUT_COUNT_W-1:0] r_s1_count;
    logic                            r_s1_overflow;

    // output register
    logic                            r_out_valid;
    logic                            r_out_read_valid;
    logic [urf_pkg::DATA_W-1:0]      r_out_read_data;
    logic                            r_out_byte_done;
    logic [urf_pkg::OUT_COUNT_W-1:0] r_out_count;
    logic                            r_out_overflow;

    logic                       in_accept;
    logic                       tick;
    logic                       pop;
    logic                       out_free;
    logic                       s1_move;
    urf_pkg::t_rx_word          rx_word;
    urf_pkg::t_fifo_status      fifo_status;
    logic [urf_pkg::DATA_W-1:0] fifo_rd_data;

    // output register frees up when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    // hold input only while stage one is full and cannot drain
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign tick       = in_accept && (i_action == urf_pkg::ACT_TICK);
    assign pop        = in_accept && (i_action == urf_pkg::ACT_READ);

    // ticks per bit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= urf_pkg::PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_bit_period <= i_cfg_wr_data;
        end
    end

    urf_rx u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick),
        .i_line       (i_rx_line),
        .i_bit_period (r_bit_period),
        .o_word       (rx_word)
    );

    urf_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (rx_word),
        .i_pop     (pop),
        .o_status  (fifo_status),
        .o_rd_data (fifo_rd_data)
    );

    // stage one valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_read_valid <= fifo_status.pop_ok;
            r_s1_byte_done  <= rx_word.push;
            r_s1_count      <= urf_pkg::OUT_COUNT_W'(fifo_status.count);
            r_s1_overflow   <= fifo_status.overflow;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload; ram data holds while stage one waits, since no new
    // read is accepted then
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_read_valid <= r_s1_read_valid;
            r_out_read_data  <= r_s1_read_valid ? fifo_rd_data : '0;
            r_out_byte_done  <= r_s1_byte_done;
            r_out_count      <= r_s1_count;
            r_out_overflow   <= r_s1_overflow;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_valid = r_out_read_valid;
    assign o_read_data  = r_out_read_data;
    assign o_byte_done  = r_out_byte_done;
    assign o_fifo_count = r_out_count;
    assign o_overflow   = r_out_overflow;

endmodule

@@ rtl/core/urf_ram.sv @@
// generic single write port, single read port ram with registered read
module urf_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/urf_rx.sv @@
// start edge detect, mid-bit sampling and deserializer
module urf_rx (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tick,
    input  logic                         i_line,
    input  logic [urf_pkg::PERIOD_W-1:0] i_bit_period,
    output urf_pkg::t_rx_word            o_word
);

    urf_pkg::t_rx_state r_state, n_state;
    logic                         r_last_level, n_last_level;
    logic [urf_pkg::TICK_W-1:0]   r_tick_count, n_tick_count;
    logic [urf_pkg::BITS_W-1:0]   r_bits_taken, n_bits_taken;
    logic [urf_pkg::DATA_W-1:0]   r_shift, n_shift;

    logic [urf_pkg::PERIOD_W-1:0] period;
    logic [urf_pkg::TICK_W-1:0]   tick_dec;
    logic [urf_pkg::BITS_W-1:0]   bits_inc;
    logic [urf_pkg::DATA_W-1:0]   shifted;

    // zero period behaves as one tick
    assign period   = (i_bit_period == '0) ? urf_pkg::PERIOD_W'(1) : i_bit_period;
    assign tick_dec = (r_tick_count != '0) ? r_tick_count - 1'b1 : r_tick_count;
    assign bits_inc = r_bits_taken + 1'b1;
    assign shifted  = {i_line, r_shift[urf_pkg::DATA_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= urf_pkg::RX_IDLE;
            r_last_level <= 1'b1;
            r_tick_count <= '0;
            r_bits_taken <= '0;
            r_shift      <= '0;
        end else begin
            r_state      <= n_state;
            r_last_level <= n_last_level;
            r_tick_count <= n_tick_count;
            r_bits_taken <= n_bits_taken;
            r_shift      <= n_shift;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_last_level = r_last_level;
        n_tick_count = r_tick_count;
        n_bits_taken = r_bits_taken;
        n_shift      = r_shift;
        o_word.push  = 1'b0;
        o_word.data  = shifted;
        if (i_tick) begin
            n_last_level = i_line;
            case (r_state)
                urf_pkg::RX_IDLE: begin
                    if (r_last_level && !i_line) begin
                        // first sample lands one and a half bits after the edge
                        n_state      = urf_pkg::RX_DATA;
                        n_tick_count = {1'b0, period} + {2'b00, period[urf_pkg::PERIOD_W-1:1]};
                        n_bits_taken = '0;
                        n_shift      = '0;
                    end
                end
                urf_pkg::RX_DATA: begin
                    n_tick_count = tick_dec;
                    if (tick_dec == '0) begin
                        n_shift      = shifted;
                        n_bits_taken = bits_inc;
                        n_tick_count = {1'b0, period};
                        if (bits_inc >= urf_pkg::BITS_W'(urf_pkg::BITS_PER_WORD)) begin
                            o_word.push  = 1'b1;
                            n_state      = urf_pkg::RX_IDLE;
                            n_bits_taken = '0;
                            n_shift      = '0;
                            n_tick_count = '0;
                        end
                    end
                end
                default: begin
                    n_state = urf_pkg::RX_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/urf_fifo.sv @@
// receive fifo: pointers, fill count, overflow flag and the byte memory
module urf_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  urf_pkg::t_rx_word          i_push,
    input  logic                       i_pop,
    output urf_pkg::t_fifo_status      o_status,
    output logic [urf_pkg::DATA_W-1:0] o_rd_data
);

    logic [urf_pkg::ADDR_W-1:0] r_wp, n_wp;
    logic [urf_pkg::ADDR_W-1:0] r_rp, n_rp;
    logic [urf_pkg::CNT_W-1:0]  r_count, n_count;
    logic                       r_overflow, n_overflow;

    logic full;
    logic empty;
    logic do_write;
    logic do_read;

    function automatic logic [urf_pkg::ADDR_W-1:0] next_index(
        input logic [urf_pkg::ADDR_W-1:0] p
    );
        next_index = (p == urf_pkg::ADDR_W'(urf_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (r_count == urf_pkg::CNT_W'(urf_pkg::FIFO_DEPTH));
    assign empty    = (r_count == '0);
    assign do_write = i_push.push && !full;
    assign do_read  = i_pop && !empty;

    always_comb begin
        n_wp       = do_write ? next_index(r_wp) : r_wp;
        n_rp       = do_read ? next_index(r_rp) : r_rp;
        n_overflow = r_overflow | (i_push.push && full);
        n_count    = r_count;
        if (do_write && !do_read) begin
            n_count = r_count + 1'b1;
        end else if (do_read && !do_write) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    assign o_status.count    = n_count;
    assign o_status.overflow = n_overflow;
    assign o_status.pop_ok   = do_read;

    // read address is taken on the pop edge, data shows in the following cycle
    urf_ram #(
        .DEPTH (urf_pkg::FIFO_DEPTH),
        .WIDTH (urf_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_wp),
        .i_wdata (i_push.data),
        .i_re    (do_read),
        .i_raddr (r_rp),
        .o_rdata (o_rd_data)
    );

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= urf_pkg::CNT_W'(urf_pkg::FIFO_DEPTH))
        else $error("fifo count beyond depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp == r_rp) == (empty || full))
        else $error("fifo pointers disagree with count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_write && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not raise count");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |=> r_overflow)
        else $error("overflow flag cleared");
`endif

endmodule

@@ tb/sv/tb_uart_8n1_receiver_fifo.sv @@
// self-checking testbench for the tick-driven 8n1 uart receiver with receive fifo
module tb_uart_8n1_receiver_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200_000;
    // output pipeline is two deep, leave a margin before touching bit_period
    localparam int SETTLE_CYCLES = 4;

    // one input word as the sender presents it
    typedef struct packed {
        urf_pkg::t_action act;
        logic             line;
    } t_line_word;

    // one result word, field order matches the output ports
    typedef struct packed {
        logic                            read_valid;
        logic [urf_pkg::DATA_W-1:0]      read_data;
        logic                            byte_done;
        logic [urf_pkg::OUT_COUNT_W-1:0] fifo_count;
        logic                            overflow;
    } t_uart_result;

    // every block input starts at a known value
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [urf_pkg::PERIOD_W-1:0]    i_cfg_wr_data = '0;
    logic                            i_in_valid    = 1'b0;
    logic                            i_action      = urf_pkg::ACT_TICK;
    logic                            i_rx_line     = 1'b1;
    logic                            i_out_stall   = 1'b0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic                            o_read_valid;
    logic [urf_pkg::DATA_W-1:0]      o_read_data;
    logic                            o_byte_done;
    logic [urf_pkg::OUT_COUNT_W-1:0] o_fifo_count;
    logic                            o_overflow;

    uart_8n1_receiver_fifo dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_rx_line    (i_rx_line),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_valid (o_read_valid),
        .o_read_data  (o_read_data),
        .o_byte_done  (o_byte_done),
        .o_fifo_count (o_fifo_count),
        .o_overflow   (o_overflow)
    );

    always #5ns i_clk = ~i_clk;

    // stimulus words waiting for the driver, and results waiting for the dut
    t_line_word   line_words[$];
    t_uart_result predicted_results[$];

    int          words_queued  = 0;
    int          words_sent    = 0;
    int          error_count   = 0;
    int          bytes_done    = 0;
    int          reads_hit     = 0;
    int          periods_used  = 1;
    int          cycle_count   = 0;
    int          max_count     = 0;
    int unsigned idle_pct      = 34;
    logic        word_taken    = 1'b0;
    logic        overflow_hit  = 1'b0;

    // receiver shadow state, same reset values as the block
    logic [urf_pkg::PERIOD_W-1:0] period_reg    = urf_pkg::PERIOD_RESET;
    logic                         rx_busy       = 1'b0;
    logic                         prev_line     = 1'b1;
    int unsigned                  countdown     = 0;
    int unsigned                  bits_seen     = 0;
    logic [urf_pkg::DATA_W-1:0]   shift_reg     = '0;
    logic [urf_pkg::DATA_W-1:0]   held_bytes[$];
    logic                         overflow_flag = 1'b0;

    // advance the shadow receiver by one accepted word and return its result
    function automatic t_uart_result step_receiver(input urf_pkg::t_action act,
                                                   input logic line);
        t_uart_result res;
        int unsigned  eff;
        res = '0;
        // a bit period of zero behaves as one tick per bit
        eff = (period_reg == '0) ? 32'd1 : 32'(period_reg);
        if (act == urf_pkg::ACT_READ) begin
            // read on an empty fifo returns zeros and changes nothing
            if (held_bytes.size() != 0) begin
                res.read_valid = 1'b1;
                res.read_data  = held_bytes.pop_front();
            end
        end else begin
            if (!rx_busy) begin
                // start bit: first sample one and a half bit periods later
                if (prev_line && !line) begin
                    rx_busy   = 1'b1;
                    countdown = eff + eff / 2;
                    bits_seen = 0;
                    shift_reg = '0;
                end
            end else begin
                // edges seen here are ignored, only the countdown matters
                if (countdown > 0)
                    countdown--;
                if (countdown == 0) begin
                    shift_reg = {line, shift_reg[urf_pkg::DATA_W-1:1]};
                    bits_seen++;
                    countdown = eff;
                    if (bits_seen == urf_pkg::BITS_PER_WORD) begin
                        // full fifo drops the byte but still flags completion
                        if (held_bytes.size() >= urf_pkg::FIFO_DEPTH)
                            overflow_flag = 1'b1;
                        else
                            held_bytes.push_back(shift_reg);
                        res.byte_done = 1'b1;
                        rx_busy       = 1'b0;
                        bits_seen     = 0;
                        countdown     = 0;
                    end
                end
            end
            prev_line = line;
        end
        res.fifo_count = urf_pkg::OUT_COUNT_W'(held_bytes.size());
        res.overflow   = overflow_flag;
        return res;
    endfunction

    // input side, sampling half: a word is taken when valid and not stalled
    always @(posedge i_clk) begin
        word_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predicted_results.push_back(
                step_receiver(urf_pkg::t_action'(i_action), i_rx_line));
            words_sent++;
        end
    end

    // input side, driving half: present the next word or idle, hold while stalled
    always @(negedge i_clk) begin
        t_line_word next_word;
        if (!i_in_valid || word_taken) begin
            if (i_rst_n && line_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                next_word = line_words.pop_front();
                i_in_valid <= 1'b1;
                i_action   <= next_word.act;
                i_rx_line  <= next_word.line;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        // receiver side backpressure, independent of the sender
        i_out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    // output side: compare every taken result word with the oldest prediction
    always @(posedge i_clk) begin
        t_uart_result got;
        t_uart_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_read_valid, o_read_data, o_byte_done, o_fifo_count, o_overflow};
            if (predicted_results.size() == 0) begin
                error_count++;
                $display("%0t: result word with none expected: rv=%0b rd=%02h done=%0b cnt=%0d ovf=%0b",
                         $time, got.read_valid, got.read_data, got.byte_done,
                         got.fifo_count, got.overflow);
            end else begin
                want = predicted_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch expected rv=%0b rd=%02h done=%0b cnt=%0d ovf=%0b",
                             $time, want.read_valid, want.read_data, want.byte_done,
                             want.fifo_count, want.overflow);
                    $display("%0t:            actual rv=%0b rd=%02h done=%0b cnt=%0d ovf=%0b",
                             $time, got.read_valid, got.read_data, got.byte_done,
                             got.fifo_count, got.overflow);
                end
            end
            if (got.byte_done === 1'b1)
                bytes_done++;
            if (got.read_valid === 1'b1)
                reads_hit++;
            if (got.overflow === 1'b1)
                overflow_hit = 1'b1;
            if (int'(got.fifo_count) > max_count)
                max_count = int'(got.fifo_count);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("uart_8n1_receiver_fifo test failed");
            $finish;
        end
    end

    task automatic add_word(input urf_pkg::t_action act, input logic line);
        line_words.push_back('{act: act, line: line});
        words_queued++;
    endtask

    task automatic add_ticks(input logic line, input int unsigned count);
        repeat (count) add_word(urf_pkg::ACT_TICK, line);
    endtask

    // reads carry a random line level, which the block must ignore
    task automatic add_reads(input int unsigned count);
        repeat (count) add_word(urf_pkg::ACT_READ, 1'($urandom_range(0, 1)));
    endtask

    // start bit, eight data bits lsb first, stop bit, each eff ticks long
    task automatic add_frame(input int unsigned eff,
                             input logic [urf_pkg::DATA_W-1:0] value,
                             input bit with_reads);
        logic [9:0] frame_bits;
        frame_bits = {1'b1, value, 1'b0};
        for (int b = 0; b < 10; b++) begin
            for (int t = 0; t < eff; t++) begin
                // reads slipped in mid-frame must not disturb the receiver
                if (with_reads && $urandom_range(0, 11) == 0)
                    add_reads(1);
                add_word(urf_pkg::ACT_TICK, frame_bits[b]);
            end
        end
    endtask

    // mostly clean frames with random bytes, plus read bursts, garbled frames and idle line
    task automatic add_random_traffic(input int unsigned eff, input int unsigned count);
        int unsigned first;
        int unsigned pick;
        first = words_queued;
        while (words_queued - first < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                add_frame(eff, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                add_reads($urandom_range(0, 2));
                add_ticks(1'b1, $urandom_range(0, eff));
            end else if (pick < 82) begin
                add_reads($urandom_range(1, 4));
            end else if (pick < 94) begin
                // runt or garbled frame, then enough idle line to fall back to idle
                add_word(urf_pkg::ACT_TICK, 1'b0);
                repeat ($urandom_range(0, 9 * eff))
                    add_word(urf_pkg::ACT_TICK, 1'($urandom_range(0, 1)));
                add_ticks(1'b1, 10 * eff + 1);
            end else begin
                add_ticks(1'b1, $urandom_range(1, 3 * eff));
            end
        end
    endtask

    // sender runs dry and every predicted result has come back
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (line_words.size() != 0 || i_in_valid || predicted_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_period(input logic [urf_pkg::PERIOD_W-1:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        period_reg = value;
        periods_used++;
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned eff;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reads on an empty fifo, then one frame at the reset bit period
        add_reads(2);
        add_ticks(1'b1, 2);
        add_frame(32'(urf_pkg::PERIOD_RESET), 8'hA5, 1'b0);
        add_reads(2);

        // zero bit period, all-zero, all-one and 0x81 bytes back to back
        write_period('0);
        add_frame(1, 8'h00, 1'b0);
        add_frame(1, 8'hFF, 1'b0);
        add_frame(1, 8'h81, 1'b0);
        add_reads(4);

        // random traffic over several bit periods
        write_period(16'd1);
        add_random_traffic(1, 100);

        // a stretch with no idling on either side
        write_period(16'd2);
        wait_drained();
        idle_pct = 0;
        add_random_traffic(2, 250);
        wait_drained();
        idle_pct = 34;

        // sender holds off halfway until the pipeline is empty
        eff = $urandom_range(3, 9);
        write_period(urf_pkg::PERIOD_W'(eff));
        add_random_traffic(eff, 80);
        wait_drained();
        add_random_traffic(eff, 80);

        write_period(16'd5);
        add_random_traffic(5, 90);

        // longest bit period: start a frame whose first sample lies far beyond the run
        write_period('1);
        add_ticks(1'b1, 20);
        add_reads(2);
        add_word(urf_pkg::ACT_TICK, 1'b0);
        repeat (100)
            add_word(urf_pkg::t_action'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("run covered %0d words over %0d bit period settings: %0d bytes received, %0d read back",
                 words_sent, periods_used, bytes_done, reads_hit);
        $display("deepest fifo fill seen: %0d of %0d entries, overflow flag raised: %0b",
                 max_count, urf_pkg::FIFO_DEPTH, overflow_hit);
        if (error_count == 0) begin
            $display("uart_8n1_receiver_fifo test passed");
        end else begin
            $display("uart_8n1_receiver_fifo test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/urf_pkg.sv
rtl/core/urf_ram.sv
rtl/core/urf_rx.sv
rtl/core/urf_fifo.sv
rtl/core/uart_8n1_receiver_fifo.sv
tb/sv/tb_uart_8n1_receiver_fifo.sv
